/* rtl/zx0_pkg.sv */
// ----------------------------------------------------------------------------
// zx0_pkg
// Shared types and codes for the ZX0 stream decoder: parse phases, result
// kinds and the result record that moves between the parser and the output
// queue.
// ----------------------------------------------------------------------------
`default_nettype none

package zx0_pkg;

  // parse phase codes
  localparam logic [3:0] PH_LITG_CTRL = 4'd0;
  localparam logic [3:0] PH_LITG_DATA = 4'd1;
  localparam logic [3:0] PH_LIT       = 4'd2;
  localparam logic [3:0] PH_AFTER_LIT = 4'd3;
  localparam logic [3:0] PH_REPG_CTRL = 4'd4;
  localparam logic [3:0] PH_REPG_DATA = 4'd5;
  localparam logic [3:0] PH_AFTER_REP = 4'd6;
  localparam logic [3:0] PH_OFFG_CTRL = 4'd7;
  localparam logic [3:0] PH_OFFG_DATA = 4'd8;
  localparam logic [3:0] PH_OFFLO     = 4'd9;
  localparam logic [3:0] PH_LENG_DATA = 4'd10;
  localparam logic [3:0] PH_LENG_CTRL = 4'd11;
  localparam logic [3:0] PH_AFTER_NEW = 4'd12;

  // result kinds
  localparam logic [1:0] KIND_LIT  = 2'd0;
  localparam logic [1:0] KIND_COPY = 2'd1;
  localparam logic [1:0] KIND_END  = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  literal_value;
    logic [14:0] copy_offset;
    logic [15:0] copy_length;
    logic        last_of_run;
  } res_t;

endpackage

`default_nettype wire

/* rtl/zx0_in_q.sv */
// ----------------------------------------------------------------------------
// zx0_in_q
// Front end: takes stream bytes and holds up to two of them for the parser.
// ----------------------------------------------------------------------------
`default_nettype none

module zx0_in_q (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_stream_byte,
  output logic            q_vld_o,
  output logic [7:0]      q_byte_o,
  input  wire logic       q_pop_i
);

  logic [7:0] mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic       push;

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid & ~in_stall;
  assign q_vld_o  = (cnt_r != 2'd0);
  assign q_byte_o = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (q_pop_i) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop_i};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_stream_byte;
    end
  end

endmodule

`default_nettype wire

/* rtl/zx0_parser.sv */
// ----------------------------------------------------------------------------
// zx0_parser
// Back end: bit buffer, gamma decoder and phase tracking. One control bit,
// one literal byte or one offset-low byte per cycle while nothing stalls it.
// ----------------------------------------------------------------------------
`default_nettype none

module zx0_parser (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_vld_i,
  input  wire logic [7:0]    in_byte_i,
  output logic               in_pop_o,
  input  wire logic          out_space_i,
  output logic               push_vld_o,
  output zx0_pkg::res_t      push_o
);

  logic [7:0]    buf_r, buf_nxt;
  logic [7:0]    pos_r, pos_nxt;
  logic [14:0]   last_off_r, last_off_nxt;
  logic [15:0]   acc_r, acc_nxt;
  logic [3:0]    phase_r, phase_nxt;
  logic [15:0]   lit_left_r, lit_left_nxt;
  logic [7:0]    held_hi_r, held_hi_nxt;
  logic          pend_vld_r, pend_vld_nxt;
  zx0_pkg::res_t pend_r, pend_nxt;
  logic          flush_r, flush_nxt;

  logic          need_byte;
  logic          step_go;
  logic          bit_val;
  logic          em_vld;
  zx0_pkg::res_t em;
  logic          done;

  // a byte is due when the buffer is empty or the phase eats whole bytes
  assign need_byte = (pos_r == 8'd0) || (phase_r == zx0_pkg::PH_LIT) ||
                     (phase_r == zx0_pkg::PH_OFFLO);
  assign step_go   = ~flush_r & out_space_i & (~need_byte | in_vld_i);
  assign in_pop_o  = step_go & need_byte;

  always_comb begin
    buf_nxt      = buf_r;
    pos_nxt      = pos_r;
    last_off_nxt = last_off_r;
    acc_nxt      = acc_r;
    phase_nxt    = phase_r;
    lit_left_nxt = lit_left_r;
    held_hi_nxt  = held_hi_r;
    em_vld       = 1'b0;
    em           = '0;
    bit_val      = need_byte ? in_byte_i[7] : |(buf_r & pos_r);

    if (need_byte && (phase_r == zx0_pkg::PH_LIT)) begin
      em_vld            = 1'b1;
      em.kind           = zx0_pkg::KIND_LIT;
      em.literal_value  = in_byte_i;
      lit_left_nxt      = lit_left_r - 16'd1;
      if (lit_left_nxt == 16'd0) begin
        phase_nxt = zx0_pkg::PH_AFTER_LIT;
      end
    end else if (need_byte && (phase_r == zx0_pkg::PH_OFFLO)) begin
      last_off_nxt = {held_hi_r, 7'd0} - {8'd0, in_byte_i[7:1]};
      if (in_byte_i[0]) begin
        em_vld         = 1'b1;
        em.kind        = zx0_pkg::KIND_COPY;
        em.copy_offset = last_off_nxt;
        em.copy_length = 16'd2;
        phase_nxt      = zx0_pkg::PH_AFTER_NEW;
      end else begin
        acc_nxt   = 16'd1;
        phase_nxt = zx0_pkg::PH_LENG_DATA;
      end
    end else begin
      // refill takes the top bit in the same cycle
      if (need_byte) begin
        buf_nxt = in_byte_i;
        pos_nxt = 8'h40;
      end else begin
        pos_nxt = pos_r >> 1;
      end
      unique case (phase_r)
        zx0_pkg::PH_LITG_CTRL: begin
          if (bit_val) begin
            lit_left_nxt = acc_r;
            phase_nxt    = (acc_r != 16'd0) ? zx0_pkg::PH_LIT : zx0_pkg::PH_AFTER_LIT;
          end else begin
            phase_nxt = zx0_pkg::PH_LITG_DATA;
          end
        end
        zx0_pkg::PH_LITG_DATA: begin
          acc_nxt   = {acc_r[14:0], bit_val};
          phase_nxt = zx0_pkg::PH_LITG_CTRL;
        end
        zx0_pkg::PH_AFTER_LIT: begin
          acc_nxt   = 16'd1;
          phase_nxt = bit_val ? zx0_pkg::PH_OFFG_CTRL : zx0_pkg::PH_REPG_CTRL;
        end
        zx0_pkg::PH_REPG_CTRL: begin
          if (bit_val) begin
            em_vld         = 1'b1;
            em.kind        = zx0_pkg::KIND_COPY;
            em.copy_offset = last_off_r;
            em.copy_length = acc_r;
            phase_nxt      = zx0_pkg::PH_AFTER_REP;
          end else begin
            phase_nxt = zx0_pkg::PH_REPG_DATA;
          end
        end
        zx0_pkg::PH_REPG_DATA: begin
          acc_nxt   = {acc_r[14:0], bit_val};
          phase_nxt = zx0_pkg::PH_REPG_CTRL;
        end
        zx0_pkg::PH_AFTER_REP, zx0_pkg::PH_AFTER_NEW: begin
          acc_nxt   = 16'd1;
          phase_nxt = bit_val ? zx0_pkg::PH_OFFG_CTRL : zx0_pkg::PH_LITG_CTRL;
        end
        zx0_pkg::PH_OFFG_CTRL: begin
          if (bit_val) begin
            if (acc_r[7:0] == 8'd0) begin
              // end marker: back to the power-up state, rest of buffer dropped
              em_vld       = 1'b1;
              em.kind      = zx0_pkg::KIND_END;
              buf_nxt      = 8'd0;
              pos_nxt      = 8'd0;
              last_off_nxt = 15'd1;
              acc_nxt      = 16'd1;
              phase_nxt    = zx0_pkg::PH_LITG_CTRL;
              lit_left_nxt = 16'd0;
              held_hi_nxt  = 8'd0;
            end else begin
              held_hi_nxt = acc_r[7:0];
              phase_nxt   = zx0_pkg::PH_OFFLO;
            end
          end else begin
            phase_nxt = zx0_pkg::PH_OFFG_DATA;
          end
        end
        zx0_pkg::PH_OFFG_DATA: begin
          acc_nxt   = {8'd0, acc_r[6:0], ~bit_val};
          phase_nxt = zx0_pkg::PH_OFFG_CTRL;
        end
        zx0_pkg::PH_LENG_DATA: begin
          acc_nxt   = {acc_r[14:0], bit_val};
          phase_nxt = zx0_pkg::PH_LENG_CTRL;
        end
        zx0_pkg::PH_LENG_CTRL: begin
          if (bit_val) begin
            em_vld         = 1'b1;
            em.kind        = zx0_pkg::KIND_COPY;
            em.copy_offset = last_off_r;
            em.copy_length = acc_r + 16'd1;
            phase_nxt      = zx0_pkg::PH_AFTER_NEW;
          end else begin
            phase_nxt = zx0_pkg::PH_LENG_DATA;
          end
        end
        default: begin
          acc_nxt   = 16'd1;
          phase_nxt = zx0_pkg::PH_LITG_CTRL;
        end
      endcase
    end
  end

  // byte finished once the next step would need a fresh byte
  assign done = (pos_nxt == 8'd0) || (phase_nxt == zx0_pkg::PH_LIT) ||
                (phase_nxt == zx0_pkg::PH_OFFLO);

  // one result is held back until we know whether it is the byte's last
  always_comb begin
    pend_vld_nxt = pend_vld_r;
    pend_nxt     = pend_r;
    flush_nxt    = flush_r;
    push_vld_o   = 1'b0;
    push_o       = pend_r;
    if (flush_r) begin
      if (out_space_i) begin
        push_vld_o         = 1'b1;
        push_o.last_of_run = 1'b1;
        flush_nxt          = 1'b0;
        pend_vld_nxt       = 1'b0;
      end
    end else if (step_go) begin
      priority if (pend_vld_r && em_vld) begin
        push_vld_o         = 1'b1;
        push_o.last_of_run = 1'b0;
        pend_nxt           = em;
        flush_nxt          = done;
      end else if (pend_vld_r && done) begin
        push_vld_o         = 1'b1;
        push_o.last_of_run = 1'b1;
        pend_vld_nxt       = 1'b0;
      end else if (em_vld && done) begin
        push_vld_o         = 1'b1;
        push_o             = em;
        push_o.last_of_run = 1'b1;
      end else if (em_vld) begin
        pend_nxt     = em;
        pend_vld_nxt = 1'b1;
      end else begin
        pend_vld_nxt = pend_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_r      <= 8'd0;
      pos_r      <= 8'd0;
      last_off_r <= 15'd1;
      acc_r      <= 16'd1;
      phase_r    <= zx0_pkg::PH_LITG_CTRL;
      lit_left_r <= 16'd0;
      held_hi_r  <= 8'd0;
      pend_vld_r <= 1'b0;
      flush_r    <= 1'b0;
    end else begin
      if (step_go) begin
        buf_r      <= buf_nxt;
        pos_r      <= pos_nxt;
        last_off_r <= last_off_nxt;
        acc_r      <= acc_nxt;
        phase_r    <= phase_nxt;
        lit_left_r <= lit_left_nxt;
        held_hi_r  <= held_hi_nxt;
      end
      pend_vld_r <= pend_vld_nxt;
      flush_r    <= flush_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
  end

endmodule

`default_nettype wire

/* rtl/zx0_out_q.sv */
// ----------------------------------------------------------------------------
// zx0_out_q
// Two-entry result queue in front of the output port.
// ----------------------------------------------------------------------------
`default_nettype none

module zx0_out_q (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push_vld_i,
  input  wire zx0_pkg::res_t push_i,
  output logic               space_o,
  output logic               out_valid,
  input  wire logic          out_stall,
  output zx0_pkg::res_t      out_res_o
);

  zx0_pkg::res_t mem_r [2];
  logic          wr_ptr_r;
  logic          rd_ptr_r;
  logic [1:0]    cnt_r;
  logic          pop;

  assign space_o   = (cnt_r != 2'd2);
  assign out_valid = (cnt_r != 2'd0);
  assign pop       = out_valid & ~out_stall;
  assign out_res_o = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push_vld_i) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_r + {1'b0, push_vld_i} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push_vld_i) begin
      mem_r[wr_ptr_r] <= push_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/zx0_stream_decoder.sv */
// ----------------------------------------------------------------------------
// zx0_stream_decoder
// ZX0 (v2) stream parser: compressed bytes in, literal / copy / end beats out.
// ----------------------------------------------------------------------------
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+-------------------------------
//   in_      | in        | in_valid/in_stall  | stream_byte[7:0]
//   out_     | out       | out_valid/out_stall| kind, literal_value,
//            |           |                    | copy_offset, copy_length,
//            |           |                    | last_of_run
//
// A byte that refills the bit buffer is decoded one control bit per cycle
// through the parser's bit loop while nothing stalls it (the top bit is
// decoded in the cycle the byte is loaded); it stops early when an inline
// byte falls due. Literal and offset-low bytes are consumed whole, followed by
// the decoding of any control bits still left in the buffer.
// A byte that yields several results may need a flush step to mark its last.
// Reset (rst_n low, synchronous) empties both queues and returns the parser
// to the start of a stream. Output stalls back up through a two-entry result
// queue; the input queue keeps taking beats while the parser works, up to two.
// ----------------------------------------------------------------------------
`default_nettype none

module zx0_stream_decoder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // compressed byte beats
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_stream_byte,
  // result beats
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_kind,
  output logic [7:0]       out_literal_value,
  output logic [14:0]      out_copy_offset,
  output logic [15:0]      out_copy_length,
  output logic             out_last_of_run
);

  logic          q_vld;
  logic [7:0]    q_byte;
  logic          q_pop;
  logic          out_space;
  logic          push_vld;
  zx0_pkg::res_t push_res;
  zx0_pkg::res_t out_res;

  // front: byte queue
  zx0_in_q u_in_q (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_stream_byte (in_stream_byte),
    .q_vld_o        (q_vld),
    .q_byte_o       (q_byte),
    .q_pop_i        (q_pop)
  );

  // back: bit buffer, gamma codes, phase machine
  zx0_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_vld_i    (q_vld),
    .in_byte_i   (q_byte),
    .in_pop_o    (q_pop),
    .out_space_i (out_space),
    .push_vld_o  (push_vld),
    .push_o      (push_res)
  );

  // result queue, decouples parser from downstream stalls
  zx0_out_q u_out_q (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_vld_i (push_vld),
    .push_i     (push_res),
    .space_o    (out_space),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_res_o  (out_res)
  );

  assign out_kind          = out_res.kind;
  assign out_literal_value = out_res.literal_value;
  assign out_copy_offset   = out_res.copy_offset;
  assign out_copy_length   = out_res.copy_length;
  assign out_last_of_run   = out_res.last_of_run;

endmodule

`default_nettype wire

/* rtl/zx0_checker.sv */
// ----------------------------------------------------------------------------
// zx0_checker
// Port-level checks on the decoder's result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module zx0_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [1:0]  out_kind,
  input wire logic [7:0]  out_literal_value,
  input wire logic [14:0] out_copy_offset,
  input wire logic [15:0] out_copy_length,
  input wire logic        out_last_of_run
);

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  a_hold_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_kind) && $stable(out_literal_value) &&
      $stable(out_copy_offset) && $stable(out_copy_length) && $stable(out_last_of_run))
    else $error("stalled result changed");

  a_lit_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == zx0_pkg::KIND_LIT) |->
      (out_copy_offset == 15'd0) && (out_copy_length == 16'd0))
    else $error("literal beat carries copy fields");

  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == zx0_pkg::KIND_END) |->
      out_last_of_run && (out_literal_value == 8'd0) && (out_copy_offset == 15'd0))
    else $error("end beat not last of its byte");

endmodule

bind zx0_stream_decoder zx0_checker u_zx0_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_kind          (out_kind),
  .out_literal_value (out_literal_value),
  .out_copy_offset   (out_copy_offset),
  .out_copy_length   (out_copy_length),
  .out_last_of_run   (out_last_of_run)
);

`default_nettype wire

/* verif/tb_zx0_stream_decoder.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_zx0_stream_decoder
// Self-checking bench for the ZX0 stream parser. Two hand-packed directed
// streams come first. They are followed by generated well-formed streams with
// random content, then one corrupted stream and raw noise. Every accepted
// byte is run through a behavioral parser, and each result beat is compared
// field by field against the oldest predicted result.
// ----------------------------------------------------------------------------

module tb_zx0_stream_decoder;

  localparam int        MAX_PER_BYTE = 8;      // result cap per input byte
  localparam int        HOLD_CYCLES  = 300;    // long output hold-off
  localparam int        HOLD_AT      = 70;     // bytes accepted before the hold
  localparam int        RANDOM_BYTES = 100;    // well-formed part, then a bad tail
  localparam int        DRAIN_CYCLES = 40;
  localparam longint    WATCHDOG_NS  = 2_000_000;

  // --------------------------------------------------------------------------
  // DUT hookup. Every input has a known value from time zero.
  // --------------------------------------------------------------------------
  logic        clk;
  logic        rst_n          = 1'b0;
  logic        in_valid       = 1'b0;
  logic        in_stall;
  logic [7:0]  in_stream_byte = 8'h00;
  logic        out_valid;
  logic        out_stall      = 1'b0;
  logic [1:0]  out_kind;
  logic [7:0]  out_literal_value;
  logic [14:0] out_copy_offset;
  logic [15:0] out_copy_length;
  logic        out_last_of_run;

  zx0_stream_decoder uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_stream_byte    (in_stream_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_kind          (out_kind),
    .out_literal_value (out_literal_value),
    .out_copy_offset   (out_copy_offset),
    .out_copy_length   (out_copy_length),
    .out_last_of_run   (out_last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Stimulus rows. A row with 'typed' set carries its single result, written
  // out by hand; every other row is checked against the behavioral parser.
  // --------------------------------------------------------------------------
  typedef struct packed {
    logic [7:0]  data;
    logic        typed;
    logic [1:0]  kind;
    logic [7:0]  lit;
    logic [14:0] off;
    logic [15:0] len;
  } feed_row_t;

  // Two hand-packed streams. Bits are consumed MSB first from control bytes;
  // literal and offset-low bytes sit inline between them.
  feed_row_t directed_rows [0:24] = '{
    // stream 1: 1 literal, new off 1 len 2, 2 literals, rep len 1, off 32640 len 0, end
    '{8'hE2, 1'b0, zx0_pkg::KIND_LIT,  8'h00, 15'd0,     16'd0},  // 1 lit; new off; hi=1
    '{8'h00, 1'b1, zx0_pkg::KIND_LIT,  8'h00, 15'd0,     16'd0},  // literal, low extreme
    '{8'hFF, 1'b1, zx0_pkg::KIND_COPY, 8'h00, 15'd1,     16'd2},  // low byte: off 1, len 2
    '{8'hFF, 1'b1, zx0_pkg::KIND_LIT,  8'hFF, 15'd0,     16'd0},  // literal, high extreme
    '{8'hA5, 1'b1, zx0_pkg::KIND_LIT,  8'hA5, 15'd0,     16'd0},  // then rep-match gamma
    '{8'hC0, 1'b1, zx0_pkg::KIND_COPY, 8'h00, 15'd1,     16'd1},  // rep len 1; hi gamma
    '{8'h00, 1'b0, zx0_pkg::KIND_LIT,  8'h00, 15'd0,     16'd0},  // hi gamma runs to 255
    '{8'hD5, 1'b0, zx0_pkg::KIND_LIT,  8'h00, 15'd0,     16'd0},  // hi=255 stop
    '{8'h00, 1'b0, zx0_pkg::KIND_LIT,  8'h00, 15'd0,     16'd0},  // low byte 0: gamma len
    '{8'h55, 1'b0, zx0_pkg::KIND_LIT,  8'h00, 15'd0,     16'd0},
    '{8'h55, 1'b0, zx0_pkg::KIND_LIT,  8'h00, 15'd0,     16'd0},
    '{8'h57, 1'b1, zx0_pkg::KIND_COPY, 8'h00, 15'd32640, 16'd0},  // len 0xFFFF+1 wraps to 0
    '{8'h55, 1'b0, zx0_pkg::KIND_LIT,  8'h00, 15'd0,     16'd0},  // end marker gamma
    '{8'h55, 1'b0, zx0_pkg::KIND_LIT,  8'h00, 15'd0,     16'd0},
    '{8'hFF, 1'b1, zx0_pkg::KIND_END,  8'h00, 15'd0,     16'd0},  // end; spare bits dropped
    // stream 2: empty literal run, rep from reset offset, a literal, off 64 len 4, end
    '{8'h00, 1'b0, zx0_pkg::KIND_LIT,  8'h00, 15'd0,     16'd0},  // 16 zero gamma bits
    '{8'h00, 1'b0, zx0_pkg::KIND_LIT,  8'h00, 15'd0,     16'd0},
    '{8'h00, 1'b0, zx0_pkg::KIND_LIT,  8'h00, 15'd0,     16'd0},
    '{8'h00, 1'b0, zx0_pkg::KIND_LIT,  8'h00, 15'd0,     16'd0},
    '{8'hAF, 1'b1, zx0_pkg::KIND_COPY, 8'h00, 15'd1,     16'd1},  // run wraps to 0; rep
    '{8'h5A, 1'b1, zx0_pkg::KIND_LIT,  8'h5A, 15'd0,     16'd0},
    '{8'h80, 1'b0, zx0_pkg::KIND_LIT,  8'h00, 15'd0,     16'd0},  // low byte: off 64
    '{8'hD5, 1'b0, zx0_pkg::KIND_LIT,  8'h00, 15'd0,     16'd0},  // copy 64 len 4
    '{8'h55, 1'b0, zx0_pkg::KIND_LIT,  8'h00, 15'd0,     16'd0},
    '{8'h7F, 1'b1, zx0_pkg::KIND_END,  8'h00, 15'd0,     16'd0}
  };

  feed_row_t       feed[$];
  zx0_pkg::res_t   pending_results[$];   // predicted beats, oldest first
  zx0_pkg::res_t   byte_results[$];      // results of the byte just parsed

  int n_errors  = 0;
  int n_bytes   = 0;
  int n_checked = 0;
  int n_lit     = 0;
  int n_copy    = 0;
  int n_end     = 0;
  int n_streams = 0;

  // --------------------------------------------------------------------------
  // Behavioral parser
  // --------------------------------------------------------------------------
  logic [7:0]  zx_buf;
  logic [7:0]  zx_mask;     // next unread bit, 0 = buffer empty
  logic [14:0] zx_off;
  logic [15:0] zx_acc;
  logic [3:0]  zx_phase;
  logic [15:0] zx_left;
  logic [7:0]  zx_hi;

  task automatic parser_clear();
    zx_buf   = 8'h00;
    zx_mask  = 8'h00;
    zx_off   = 15'd1;
    zx_acc   = 16'd1;
    zx_phase = zx0_pkg::PH_LITG_CTRL;
    zx_left  = 16'd0;
    zx_hi    = 8'h00;
  endtask

  task automatic put_result(input logic [1:0] k, input logic [7:0] lit,
                            input logic [14:0] off, input logic [15:0] len);
    zx0_pkg::res_t r;
    if (byte_results.size() < MAX_PER_BYTE) begin
      r.kind          = k;
      r.literal_value = lit;
      r.copy_offset   = off;
      r.copy_length   = len;
      r.last_of_run   = 1'b0;
      byte_results.push_back(r);
    end
  endtask

  task automatic parser_bit(input logic b);
    case (zx_phase)
      zx0_pkg::PH_LITG_CTRL: begin
        if (b) begin
          zx_left  = zx_acc;
          zx_phase = (zx_acc != 16'd0) ? zx0_pkg::PH_LIT : zx0_pkg::PH_AFTER_LIT;
        end else begin
          zx_phase = zx0_pkg::PH_LITG_DATA;
        end
      end
      zx0_pkg::PH_LITG_DATA: begin
        zx_acc   = {zx_acc[14:0], b};
        zx_phase = zx0_pkg::PH_LITG_CTRL;
      end
      zx0_pkg::PH_AFTER_LIT: begin
        zx_acc   = 16'd1;
        zx_phase = b ? zx0_pkg::PH_OFFG_CTRL : zx0_pkg::PH_REPG_CTRL;
      end
      zx0_pkg::PH_REPG_CTRL: begin
        if (b) begin
          put_result(zx0_pkg::KIND_COPY, 8'h00, zx_off, zx_acc);
          zx_phase = zx0_pkg::PH_AFTER_REP;
        end else begin
          zx_phase = zx0_pkg::PH_REPG_DATA;
        end
      end
      zx0_pkg::PH_REPG_DATA: begin
        zx_acc   = {zx_acc[14:0], b};
        zx_phase = zx0_pkg::PH_REPG_CTRL;
      end
      zx0_pkg::PH_AFTER_REP, zx0_pkg::PH_AFTER_NEW: begin
        zx_acc   = 16'd1;
        zx_phase = b ? zx0_pkg::PH_OFFG_CTRL : zx0_pkg::PH_LITG_CTRL;
      end
      zx0_pkg::PH_OFFG_CTRL: begin
        if (b) begin
          if (zx_acc[7:0] == 8'h00) begin
            // high part wrapped: end of stream, everything back to reset
            put_result(zx0_pkg::KIND_END, 8'h00, 15'd0, 16'd0);
            parser_clear();
          end else begin
            zx_hi    = zx_acc[7:0];
            zx_phase = zx0_pkg::PH_OFFLO;
          end
        end else begin
          zx_phase = zx0_pkg::PH_OFFG_DATA;
        end
      end
      zx0_pkg::PH_OFFG_DATA: begin
        // offset high part is stored inverted and kept to 8 bits
        zx_acc   = {8'h00, zx_acc[6:0], ~b};
        zx_phase = zx0_pkg::PH_OFFG_CTRL;
      end
      zx0_pkg::PH_LENG_DATA: begin
        zx_acc   = {zx_acc[14:0], b};
        zx_phase = zx0_pkg::PH_LENG_CTRL;
      end
      zx0_pkg::PH_LENG_CTRL: begin
        if (b) begin
          put_result(zx0_pkg::KIND_COPY, 8'h00, zx_off, zx_acc + 16'd1);
          zx_phase = zx0_pkg::PH_AFTER_NEW;
        end else begin
          zx_phase = zx0_pkg::PH_LENG_DATA;
        end
      end
      default: begin
        zx_acc   = 16'd1;
        zx_phase = zx0_pkg::PH_LITG_CTRL;
      end
    endcase
  endtask

  task automatic parse_byte(input logic [7:0] b);
    logic          bitv;
    zx0_pkg::res_t tail;
    byte_results.delete();
    if (zx_phase == zx0_pkg::PH_LIT) begin
      put_result(zx0_pkg::KIND_LIT, b, 15'd0, 16'd0);
      zx_left = zx_left - 16'd1;
      if (zx_left == 16'd0) zx_phase = zx0_pkg::PH_AFTER_LIT;
    end else if (zx_phase == zx0_pkg::PH_OFFLO) begin
      zx_off = {zx_hi, 7'd0} - {8'd0, b[7:1]};
      if (b[0]) begin
        put_result(zx0_pkg::KIND_COPY, 8'h00, zx_off, 16'd2);
        zx_phase = zx0_pkg::PH_AFTER_NEW;
      end else begin
        zx_acc   = 16'd1;
        zx_phase = zx0_pkg::PH_LENG_DATA;
      end
    end else begin
      zx_buf  = b;
      zx_mask = 8'h80;
    end
    // drain whatever control bits are left, unless an inline byte is due
    while (zx_mask != 8'h00 && zx_phase != zx0_pkg::PH_LIT &&
           zx_phase != zx0_pkg::PH_OFFLO) begin
      bitv    = |(zx_buf & zx_mask);
      zx_mask = zx_mask >> 1;
      parser_bit(bitv);
    end
    if (byte_results.size() > 0) begin
      tail = byte_results.pop_back();
      tail.last_of_run = 1'b1;
      byte_results.push_back(tail);
    end
  endtask

  // --------------------------------------------------------------------------
  // Stream builder: packs control bits into bytes the way a compressor does.
  // A control byte is reserved in the output when its first bit is needed.
  // --------------------------------------------------------------------------
  logic [7:0] stream_bytes[$];
  int         ctl_idx  = 0;
  logic [7:0] ctl_mask = 8'h00;

  task automatic put_bit(input logic b);
    if (ctl_mask == 8'h00) begin
      ctl_idx = stream_bytes.size();
      stream_bytes.push_back(8'h00);
      ctl_mask = 8'h80;
    end
    if (b) stream_bytes[ctl_idx] = stream_bytes[ctl_idx] | ctl_mask;
    ctl_mask = ctl_mask >> 1;
  endtask

  // interlaced gamma: (continue, data) pairs below the leading one, then stop
  task automatic put_gamma(input int nbits, input logic [15:0] v, input logic inv);
    for (int i = nbits - 1; i >= 0; i--) begin
      put_bit(1'b0);
      put_bit(v[i] ^ inv);
    end
    put_bit(1'b1);
  endtask

  // length after an even offset-low byte: data first, its stop bit follows
  task automatic put_len_gamma(input int nbits, input logic [15:0] v);
    for (int i = nbits - 1; i >= 0; i--) begin
      put_bit(v[i]);
      put_bit(i == 0);
    end
  endtask

  function automatic int top_bit(input logic [15:0] v);
    int k;
    k = 0;
    for (int i = 0; i < 16; i++) if (v[i]) k = i;
    return k;
  endfunction

  task automatic put_literal_run();
    logic [15:0] cnt;
    if ($urandom_range(0, 15) == 0) begin
      put_gamma(16, 16'h0000, 1'b0);            // count wraps to an empty run
    end else begin
      cnt = 16'($urandom_range(1, 6));
      put_gamma(top_bit(cnt), cnt, 1'b0);
      repeat (cnt) stream_bytes.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic build_stream();
    int          n_cmds;
    logic        after_lit;
    logic [15:0] v;
    logic [7:0]  hi;
    logic [7:0]  lo;
    n_cmds = $urandom_range(1, 6);
    put_literal_run();                          // a stream always opens on literals
    after_lit = 1'b1;
    repeat (n_cmds) begin
      if ($urandom_range(0, 1) == 0) begin
        put_bit(1'b0);
        if (after_lit) begin
          // match from the last offset
          if ($urandom_range(0, 11) == 0) begin
            put_gamma(16, 16'h0000, 1'b0);      // length wraps to 0
          end else begin
            v = 16'($urandom_range(1, 40));
            put_gamma(top_bit(v), v, 1'b0);
          end
          after_lit = 1'b0;
        end else begin
          put_literal_run();
          after_lit = 1'b1;
        end
      end else begin
        // match from a new offset
        put_bit(1'b1);
        if ($urandom_range(0, 3) == 0) hi = ($urandom_range(0, 1) == 1) ? 8'd255 : 8'd1;
        else hi = 8'($urandom_range(1, 255));
        put_gamma(top_bit({8'h00, hi}), {8'h00, hi}, 1'b1);
        lo = 8'($urandom_range(0, 255));
        stream_bytes.push_back(lo);
        if (!lo[0]) begin
          v = ($urandom_range(0, 11) == 0) ? 16'hFFFF : 16'($urandom_range(2, 60));
          put_len_gamma(top_bit(v), v);
        end
        after_lit = 1'b0;
      end
    end
    // end marker: new-offset flag, then a high part that wraps to zero
    put_bit(1'b1);
    put_gamma(8, 16'h0000, 1'b1);
    ctl_mask = 8'h00;                            // spare bits are dropped
  endtask

  // --------------------------------------------------------------------------
  // Mismatch reporting
  // --------------------------------------------------------------------------
  task automatic flag_mismatch(input string what);
    n_errors++;
    $display("[%0t] ERROR %s", $time, what);
  endtask

  // --------------------------------------------------------------------------
  // Result checker: every beat taken at a rising edge is matched against the
  // oldest prediction.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    zx0_pkg::res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        flag_mismatch($sformatf("result beat with nothing predicted (kind %0d)", out_kind));
      end else begin
        want = pending_results.pop_front();
        if (out_kind !== want.kind)
          flag_mismatch($sformatf("beat %0d kind %0d, predicted %0d",
                                  n_checked, out_kind, want.kind));
        if (out_literal_value !== want.literal_value)
          flag_mismatch($sformatf("beat %0d literal 0x%02h, predicted 0x%02h",
                                  n_checked, out_literal_value, want.literal_value));
        if (out_copy_offset !== want.copy_offset)
          flag_mismatch($sformatf("beat %0d offset %0d, predicted %0d",
                                  n_checked, out_copy_offset, want.copy_offset));
        if (out_copy_length !== want.copy_length)
          flag_mismatch($sformatf("beat %0d length %0d, predicted %0d",
                                  n_checked, out_copy_length, want.copy_length));
        if (out_last_of_run !== want.last_of_run)
          flag_mismatch($sformatf("beat %0d last flag %0b, predicted %0b",
                                  n_checked, out_last_of_run, want.last_of_run));
        case (want.kind)
          zx0_pkg::KIND_LIT:  n_lit++;
          zx0_pkg::KIND_COPY: n_copy++;
          default:            n_end++;
        endcase
        n_checked++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result-side backpressure. The stall pattern is redrawn at random between
  // none, heavy random, light random, or a regular periodic stall. Once, after
  // HOLD_AT bytes, the output is held off long enough for both internal
  // queues to fill so in_stall has to rise while the sender keeps offering.
  // --------------------------------------------------------------------------
  initial begin : receiver
    int   cyc;
    int   mode;
    logic held;
    cyc  = 0;
    mode = 0;
    held = 1'b0;
    while (!rst_n) @(negedge clk);
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc % 48 == 0) mode = $urandom_range(0, 3);
      if (!held && n_bytes >= HOLD_AT) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 1) == 1);
          2:       out_stall <= ($urandom_range(0, 3) == 0);
          default: out_stall <= (cyc % 3 == 0);
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence: build the byte feed, reset, drive bytes in bursts, drain.
  // Inputs change on the falling edge; acceptance is seen at the rising edge.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int            burst_left;
    int            gap;
    int            start;
    int            flip;
    feed_row_t     row;
    zx0_pkg::res_t hand;

    foreach (directed_rows[i]) feed.push_back(directed_rows[i]);

    // mostly well-formed streams so parsing gets past its first phases
    while (stream_bytes.size() < RANDOM_BYTES) begin
      build_stream();
      n_streams++;
    end
    // then one stream with a flipped bit, followed by noise
    start = stream_bytes.size();
    build_stream();
    flip = $urandom_range(start, stream_bytes.size() - 1);
    stream_bytes[flip] = stream_bytes[flip] ^ 8'(1 << $urandom_range(0, 7));
    repeat (16) stream_bytes.push_back(8'($urandom_range(0, 255)));
    foreach (stream_bytes[i]) begin
      row      = '0;
      row.data = stream_bytes[i];
      feed.push_back(row);
    end

    parser_clear();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    burst_left = 0;
    foreach (feed[i]) begin
      if (burst_left == 0) begin
        gap        = $urandom_range(0, 5);
        burst_left = $urandom_range(1, 16);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      in_valid       <= 1'b1;
      in_stream_byte <= feed[i].data;
      @(posedge clk);
      while (in_stall) @(posedge clk);
      // beat taken at this edge
      parse_byte(feed[i].data);
      if (feed[i].typed) begin
        hand.kind          = feed[i].kind;
        hand.literal_value = feed[i].lit;
        hand.copy_offset   = feed[i].off;
        hand.copy_length   = feed[i].len;
        hand.last_of_run   = 1'b1;
        pending_results.push_back(hand);
      end else begin
        foreach (byte_results[j]) pending_results.push_back(byte_results[j]);
      end
      n_bytes++;
      burst_left--;
      @(negedge clk);
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d bytes: %0d hand-packed, %0d built streams, a corrupted one, noise.",
             n_bytes, $size(directed_rows), n_streams);
    $display("Checked %0d beats (%0d literal, %0d copy, %0d end), one %0d-cycle hold-off.",
             n_checked, n_lit, n_copy, n_end, HOLD_CYCLES);
    if (n_errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Watchdog
  // --------------------------------------------------------------------------
  initial begin : watchdog
    #(WATCHDOG_NS);
    $display("Watchdog expired: %0d bytes sent, %0d beats still predicted.",
             n_bytes, pending_results.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

/* sim.f */
rtl/zx0_pkg.sv
rtl/zx0_in_q.sv
rtl/zx0_parser.sv
rtl/zx0_out_q.sv
rtl/zx0_stream_decoder.sv
rtl/zx0_checker.sv
verif/tb_zx0_stream_decoder.sv
